// ===== sv/colmap_pkg.sv =====
// colmap_pkg: shared constants and types for the colormap interpolation block
`default_nettype none

package colmap_pkg;

   localparam int MAX_COLORS = 256;
   localparam int FRAC_BITS  = 16;
   localparam int IDX_W      = $clog2(MAX_COLORS);
   localparam int COLOR_W    = 8;
   localparam int HEIGHT_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int SCALE_RESET = 1 << FRAC_BITS;
   localparam int HALF        = 1 << (FRAC_BITS - 1);

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_PIXEL = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE  = 2'd0,
      CSR_OFFSET = 2'd1,
      CSR_LAST   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

endpackage

`default_nettype wire

// ===== sv/colormap_interpolate.sv =====
// colormap_interpolate: height to color mapping through a blended color table
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | func, color_index, load rgb, height_sample
//   rsp     | out       | rsp_valid/rsp_stall | out_red, out_green, out_blue
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one item per cycle while req_stall is low; a pixel result passes through every stage below before it appears on rsp
// stages: multiply, offset and clamp, table read (two read ports), blend into output register
// loads write the table in the read stage, so a later pixel always sees them
// synchronous reset clears valids and configuration registers; the color table is not cleared
// a stalled result only blocks input once all three inner stages hold items, the third a pixel
`default_nettype none

module colormap_interpolate (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_func,
   input  wire logic [colmap_pkg::IDX_W-1:0]          req_color_index,
   input  wire logic [colmap_pkg::COLOR_W-1:0]        req_load_red,
   input  wire logic [colmap_pkg::COLOR_W-1:0]        req_load_green,
   input  wire logic [colmap_pkg::COLOR_W-1:0]        req_load_blue,
   input  wire logic signed [colmap_pkg::HEIGHT_W-1:0] req_height_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [colmap_pkg::COLOR_W-1:0]             rsp_out_red,
   output logic [colmap_pkg::COLOR_W-1:0]             rsp_out_green,
   output logic [colmap_pkg::COLOR_W-1:0]             rsp_out_blue,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [colmap_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [colmap_pkg::CSR_DATA_W-1:0]     csr_data
);
   import colmap_pkg::*;

   localparam int PROD_W = CSR_DATA_W + HEIGHT_W;
   localparam int POS_W  = PROD_W + 1;
   localparam int TOP_W  = IDX_W + FRAC_BITS;
   localparam int MIX_W  = FRAC_BITS + COLOR_W + 2;

   function automatic logic [COLOR_W-1:0] mix(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] t);
      logic signed [MIX_W-1:0] diff;
      logic signed [MIX_W-1:0] frac;
      logic signed [MIX_W-1:0] sum;
      diff = signed'(MIX_W'(b)) - signed'(MIX_W'(a));
      frac = signed'(MIX_W'(t));
      sum  = (signed'(MIX_W'(a)) <<< FRAC_BITS) + frac * diff + signed'(MIX_W'(HALF));
      return sum[FRAC_BITS +: COLOR_W];
   endfunction

   // configuration
   logic signed [CSR_DATA_W-1:0] scale_ff;
   logic signed [CSR_DATA_W-1:0] offset_ff;
   logic [IDX_W-1:0]             last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= CSR_DATA_W'(SCALE_RESET);
         offset_ff <= '0;
         last_ff   <= IDX_W'(MAX_COLORS - 1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCALE:  scale_ff  <= csr_data;
            CSR_OFFSET: offset_ff <= csr_data;
            CSR_LAST:   last_ff   <= csr_data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, pix3_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !rsp_valid_ff || !rsp_stall;
   assign rdy3 = !v3_ff || !pix3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;
   assign rsp_valid = rsp_valid_ff;

   // stage 1: multiply
   logic                     func1_ff;
   logic [IDX_W-1:0]         idx1_ff;
   rgb_type                  rgb1_ff;
   logic signed [PROD_W-1:0] prod1_ff;
   logic signed [PROD_W-1:0] prod1_in;

   assign prod1_in = scale_ff * req_height_sample;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         func1_ff <= req_func;
         idx1_ff  <= req_color_index;
         rgb1_ff  <= '{red: req_load_red, green: req_load_green, blue: req_load_blue};
         prod1_ff <= prod1_in;
      end
   end

   // stage 2: offset, clamp, split
   logic signed [POS_W-1:0] pos_in;
   logic [TOP_W-1:0]        top_in;
   logic [IDX_W-1:0]        k_in;
   logic [FRAC_BITS-1:0]    t_in;
   logic                    hold_in;

   logic                    func2_ff;
   logic [IDX_W-1:0]        idx2_ff;
   rgb_type                 rgb2_ff;
   logic [IDX_W-1:0]        k2_ff;
   logic [FRAC_BITS-1:0]    t2_ff;
   logic                    hold2_ff;

   assign pos_in = POS_W'(prod1_ff) + POS_W'(offset_ff);
   assign top_in = {last_ff, FRAC_BITS'(0)};

   always_comb begin
      if (pos_in[POS_W-1]) begin
         k_in = '0;
         t_in = '0;
      end else if (pos_in[POS_W-2:0] > (POS_W-1)'(top_in)) begin
         k_in = last_ff;
         t_in = '0;
      end else begin
         k_in = pos_in[TOP_W-1:FRAC_BITS];
         t_in = pos_in[FRAC_BITS-1:0];
      end
      hold_in = (k_in == last_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         func2_ff <= func1_ff;
         idx2_ff  <= idx1_ff;
         rgb2_ff  <= rgb1_ff;
         k2_ff    <= k_in;
         t2_ff    <= t_in;
         hold2_ff <= hold_in;
      end
   end

   // stage 3: color table access
   rgb_type              color_mem [MAX_COLORS];
   rgb_type              c0_ff;
   rgb_type              c1_ff;
   logic [FRAC_BITS-1:0] t3_ff;
   logic                 hold3_ff;
   logic [IDX_W-1:0]     k_next;
   logic                 mem_we;
   logic                 mem_re;

   assign k_next = k2_ff + IDX_W'(1);
   assign mem_we = rdy3 && v2_ff && (func2_ff == FUNC_LOAD);
   assign mem_re = rdy3 && v2_ff && (func2_ff == FUNC_PIXEL);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         color_mem[idx2_ff] <= rgb2_ff;
      end
      if (mem_re) begin
         c0_ff <= color_mem[k2_ff];
         c1_ff <= color_mem[k_next];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         t3_ff    <= t2_ff;
         hold3_ff <= hold2_ff;
      end
   end

   // stage 4: blend into output register
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff && pix3_ff) begin
         if (hold3_ff) begin
            red_ff   <= c0_ff.red;
            green_ff <= c0_ff.green;
            blue_ff  <= c0_ff.blue;
         end else begin
            red_ff   <= mix(c0_ff.red, c1_ff.red, t3_ff);
            green_ff <= mix(c0_ff.green, c1_ff.green, t3_ff);
            blue_ff  <= mix(c0_ff.blue, c1_ff.blue, t3_ff);
         end
      end
   end

   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;

   // valid tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         pix3_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff   <= v2_ff;
            pix3_ff <= (func2_ff == FUNC_PIXEL);
         end
         if (rdy4) begin
            rsp_valid_ff <= v3_ff && pix3_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/colmap_check.sv =====
// colmap_check: port-level assertions for the colormap block, bound to the top level
`default_nettype none

module colmap_check (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [colmap_pkg::COLOR_W-1:0]    rsp_out_red,
   input wire logic [colmap_pkg::COLOR_W-1:0]    rsp_out_green,
   input wire logic [colmap_pkg::COLOR_W-1:0]    rsp_out_blue
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue))
      else $error("result changed while stalled");

   // input backs up only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind colormap_interpolate colmap_check u_colmap_check (.*);

`default_nettype wire
